### sv/itrd_pkg.sv
package itrd_pkg;

  localparam int VALUE_W         = 32;
  localparam int MAG_W           = VALUE_W - 1;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;
  localparam int CHAR_W          = 7;
  localparam int MAX_DIGIT_COUNT = 32;
  localparam int STACK_AW        = $clog2(MAX_DIGIT_COUNT);
  localparam int COUNT_W         = STACK_AW + 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int BITS_PER_CYCLE  = 8;
  localparam int STEP_W          = $clog2(VALUE_W / BITS_PER_CYCLE);

  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO          = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_LETTER_OFFSET = CHAR_W'(55);
  localparam logic [DIGIT_W-1:0] LARGEST_DECIMAL     = DIGIT_W'(9);

  // Classified work item handed from front to back
  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic [RADIX_W-1:0] radix;
    logic               no_digits;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              is_last;
    logic              is_empty;
  } result_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d > LARGEST_DECIMAL) begin
      return d_ext + ASCII_LETTER_OFFSET;
    end
    return d_ext + ASCII_ZERO;
  endfunction

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) begin
      return RADIX_MIN;
    end
    if (r > RADIX_MAX) begin
      return RADIX_MAX;
    end
    return r;
  endfunction

endpackage

### sv/integer_to_radix_digits_core.sv
// Channel   | Direction | Signals                         | Transfer when
// ----------+-----------+---------------------------------+----------------------
// config    | in        | cfg_valid, cfg_ready, cfg_data  | cfg_valid && cfg_ready
// input     | in        | push, full, value               | push && !full
// result    | out       | empty, pop, digit_char,         | pop && !empty
//           |           | is_last, is_empty               |
//
// In the back end, each digit of an item comes from the divider (eight quotient bits
// per cycle); the digits are then read back from the digit stack, one digit per cycle
// while the result queue has room. Zero or negative values skip the divider.
// Reset (rst, synchronous) empties both queues and sets the base to ten.
// A two-entry item queue lets input transfers continue while the back end works;
// a full result queue stalls only the stack read-out and the no-digit result.
module integer_to_radix_digits_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic [itrd_pkg::VALUE_W-1:0]  value,
  input  logic                          push,
  output logic                          full,
  output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
  output logic                          is_last,
  output logic                          is_empty,
  output logic                          empty,
  input  logic                          pop
);

  logic           cmd_valid;
  logic           cmd_pop;
  itrd_pkg::cmd_t cmd;

  itrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .value     (value),
    .push      (push),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  itrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .digit_char (digit_char),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .empty      (empty),
    .pop        (pop)
  );

  // The back end takes an item only from a non-empty queue
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("item taken from empty queue");

  // A no-digit result is a lone, final, blank item
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_empty) |-> (is_last && digit_char == '0))
    else $error("malformed no-digit result");

  // Digit results carry a printable digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_empty) |->
      ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
       (digit_char >= 7'd65 && digit_char <= 7'd90)))
    else $error("digit character out of range");

  // Reset leaves both sides clear on the first cycle out of it
  a_reset_clear: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not clear after reset");

endmodule

### sv/itrd_front.sv
module itrd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [itrd_pkg::RADIX_W-1:0]  cfg_data,
  input  logic [itrd_pkg::VALUE_W-1:0]  value,
  input  logic                          push,
  output logic                          full,
  output logic                          cmd_valid,
  output itrd_pkg::cmd_t                cmd,
  input  logic                          cmd_pop
);

  logic [itrd_pkg::RADIX_W-1:0] radix;
  itrd_pkg::cmd_t               cq [itrd_pkg::QUEUE_DEPTH];
  logic                         wr_ptr;
  logic                         rd_ptr;
  logic [1:0]                   cq_count;
  logic                         push_fire;
  itrd_pkg::cmd_t               cmd_new;

  assign cfg_ready = 1'b1;

  // Hold the clamped base; it is captured with each item
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrd_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= itrd_pkg::clamp_radix(cfg_data);
    end
  end

  // Classify: zero or negative values produce no digits
  always_comb begin
    cmd_new.mag       = value[itrd_pkg::MAG_W-1:0];
    cmd_new.radix     = radix;
    cmd_new.no_digits = (value == '0) || value[itrd_pkg::VALUE_W-1];
  end

  assign full      = (cq_count == 2'(itrd_pkg::QUEUE_DEPTH));
  assign push_fire = push && !full;
  assign cmd_valid = (cq_count != 2'd0);
  assign cmd       = cq[rd_ptr];

  // Store accepted items for the back end
  always_ff @(posedge clk) begin
    if (push_fire) begin
      cq[wr_ptr] <= cmd_new;
    end
  end

  // Advance queue pointers on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      cq_count <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cq_count <= cq_count + 2'(push_fire) - 2'(cmd_pop);
    end
  end

endmodule

### sv/itrd_back.sv
module itrd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  itrd_pkg::cmd_t                cmd,
  output logic                          cmd_pop,
  output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
  output logic                          is_last,
  output logic                          is_empty,
  output logic                          empty,
  input  logic                          pop
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_NULL = 4'b1000
  } state_t;

  state_t                               state;
  logic [itrd_pkg::VALUE_W-1:0]         quo;
  logic [itrd_pkg::DIGIT_W-1:0]         rem;
  logic [itrd_pkg::RADIX_W-1:0]         radix_w;
  logic [itrd_pkg::STEP_W-1:0]          step;
  logic [itrd_pkg::COUNT_W-1:0]         count;
  logic [itrd_pkg::STACK_AW-1:0]        rd_idx;
  logic                                 issue_done;
  logic                                 rd_pending;
  logic                                 rd_last;
  logic [itrd_pkg::DIGIT_W-1:0]         rd_data;
  logic [itrd_pkg::DIGIT_W-1:0]         stack [itrd_pkg::MAX_DIGIT_COUNT];

  logic [itrd_pkg::DIGIT_W-1:0]         rem_step;
  logic [itrd_pkg::DIGIT_W:0]           trial;
  logic [itrd_pkg::BITS_PER_CYCLE-1:0]  qbits;
  logic [itrd_pkg::VALUE_W-1:0]         quo_step;

  itrd_pkg::result_t                    oq [itrd_pkg::QUEUE_DEPTH];
  logic                                 oq_wr;
  logic                                 oq_rd;
  logic [1:0]                           oq_count;
  logic                                 pop_fire;
  logic                                 push_digit;
  logic                                 push_null;
  itrd_pkg::result_t                    oq_in;
  logic [2:0]                           slots_used;
  logic                                 issue;

  // Restoring long division over the next byte of the dividend
  always_comb begin
    rem_step = rem;
    trial    = '0;
    qbits    = '0;
    for (int i = 0; i < itrd_pkg::BITS_PER_CYCLE; i++) begin
      trial = {rem_step, quo[itrd_pkg::VALUE_W-1-i]};
      if (trial >= {1'b0, radix_w}) begin
        trial = trial - {1'b0, radix_w};
        qbits[itrd_pkg::BITS_PER_CYCLE-1-i] = 1'b1;
      end
      rem_step = trial[itrd_pkg::DIGIT_W-1:0];
    end
    quo_step = {quo[itrd_pkg::VALUE_W-itrd_pkg::BITS_PER_CYCLE-1:0], qbits};
  end

  assign pop_fire   = pop && (oq_count != 2'd0);
  assign slots_used = {1'b0, oq_count} + {2'b0, rd_pending} - {2'b0, pop_fire};
  assign issue      = (state == ST_EMIT) && !issue_done && (slots_used < 3'(itrd_pkg::QUEUE_DEPTH));
  assign cmd_pop    = (state == ST_IDLE) && cmd_valid;
  assign push_digit = rd_pending;
  assign push_null  = (state == ST_NULL) && (oq_count < 2'(itrd_pkg::QUEUE_DEPTH));

  // Sequence: take item, divide digit by digit, then read the stack back (no-digit items give one empty marker)
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      count      <= '0;
      rd_idx     <= '0;
      issue_done <= 1'b0;
      rd_pending <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_pending <= issue;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            quo     <= {1'b0, cmd.mag};
            rem     <= '0;
            radix_w <= cmd.radix;
            step    <= '0;
            count   <= '0;
            state   <= cmd.no_digits ? ST_NULL : ST_DIV;
          end
        end
        ST_DIV: begin
          quo  <= quo_step;
          rem  <= (step == '1) ? '0 : rem_step;
          step <= step + 1'b1;
          if (step == '1) begin
            count <= count + 1'b1;
            if (quo_step == '0 || count == itrd_pkg::COUNT_W'(itrd_pkg::MAX_DIGIT_COUNT - 1)) begin
              rd_idx <= count[itrd_pkg::STACK_AW-1:0];
              state  <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (issue) begin
            rd_last <= (rd_idx == '0);
            if (rd_idx == '0) begin
              issue_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx - 1'b1;
            end
          end
          if (issue_done && !rd_pending) begin
            issue_done <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_NULL: begin
          if (push_null) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Digit stack: write on the last division step, read with registered data
  always_ff @(posedge clk) begin
    if (state == ST_DIV && step == '1) begin
      stack[count[itrd_pkg::STACK_AW-1:0]] <= rem_step;
    end
    if (issue) begin
      rd_data <= stack[rd_idx];
    end
  end

  // Result queue
  always_comb begin
    if (push_digit) begin
      oq_in.digit_char = itrd_pkg::digit_to_ascii(rd_data);
      oq_in.is_last    = rd_last;
      oq_in.is_empty   = 1'b0;
    end else begin
      oq_in.digit_char = '0;
      oq_in.is_last    = 1'b1;
      oq_in.is_empty   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_digit || push_null) begin
      oq[oq_wr] <= oq_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (push_digit || push_null) begin
        oq_wr <= ~oq_wr;
      end
      if (pop_fire) begin
        oq_rd <= ~oq_rd;
      end
      oq_count <= oq_count + 2'(push_digit || push_null) - 2'(pop_fire);
    end
  end

  assign empty      = (oq_count == 2'd0);
  assign digit_char = oq[oq_rd].digit_char;
  assign is_last    = oq[oq_rd].is_last;
  assign is_empty   = oq[oq_rd].is_empty;

endmodule

### tb/sv/tb_integer_to_radix_digits_core.sv
module tb_integer_to_radix_digits_core;

  localparam int WATCHDOG_LIMIT    = 5000;
  localparam int SETTLE_CYCLES     = 16;
  localparam int SETTINGS_PER_RUN  = 4;
  localparam int ITEMS_PER_SETTING = 25;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [itrd_pkg::RADIX_W-1:0] cfg_data  = '0;
  logic [itrd_pkg::VALUE_W-1:0] value     = '0;
  logic                         push      = 1'b0;
  logic                         full;
  logic [itrd_pkg::CHAR_W-1:0]  digit_char;
  logic                         is_last;
  logic                         is_empty;
  logic                         empty;
  logic                         pop       = 1'b0;

  // Local copy of the base register and the digits still owed by the block
  logic [itrd_pkg::RADIX_W-1:0] base_setting = itrd_pkg::RADIX_RESET;
  itrd_pkg::result_t            digits_due[$];

  int send_idle_pct = 22;
  int recv_idle_pct = 54;
  int mismatch_count;
  int values_sent;
  int digits_seen;
  int empties_seen;
  int base_writes;

  integer_to_radix_digits_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .value      (value),
    .push       (push),
    .full       (full),
    .digit_char (digit_char),
    .is_last    (is_last),
    .is_empty   (is_empty),
    .empty      (empty),
    .pop        (pop)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the digit sequence for one value, most significant first
  function automatic void predict_digits(input logic [itrd_pkg::VALUE_W-1:0] v);
    logic [itrd_pkg::RADIX_W-1:0] base;
    logic [itrd_pkg::MAG_W-1:0]   quot;
    logic [itrd_pkg::DIGIT_W-1:0] rems [itrd_pkg::MAX_DIGIT_COUNT];
    int                           n;
    itrd_pkg::result_t            item;
    base = base_setting;
    if (base < itrd_pkg::RADIX_MIN) begin
      base = itrd_pkg::RADIX_MIN;
    end else if (base > itrd_pkg::RADIX_MAX) begin
      base = itrd_pkg::RADIX_MAX;
    end
    // Zero and negative values give a single empty marker
    if (v == '0 || v[itrd_pkg::VALUE_W-1]) begin
      item.digit_char = '0;
      item.is_last    = 1'b1;
      item.is_empty   = 1'b1;
      digits_due.push_back(item);
      return;
    end
    quot = v[itrd_pkg::MAG_W-1:0];
    n    = 0;
    while (quot != '0 && n < itrd_pkg::MAX_DIGIT_COUNT) begin
      rems[n] = itrd_pkg::DIGIT_W'(quot % base);
      quot    = quot / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] > itrd_pkg::LARGEST_DECIMAL) begin
        item.digit_char = itrd_pkg::CHAR_W'(rems[k]) + itrd_pkg::ASCII_LETTER_OFFSET;
      end else begin
        item.digit_char = itrd_pkg::CHAR_W'(rems[k]) + itrd_pkg::ASCII_ZERO;
      end
      item.is_last  = (k == 0);
      item.is_empty = 1'b0;
      digits_due.push_back(item);
    end
  endfunction

  // Mix of signs, small values, wide values and values near the top
  function automatic logic [itrd_pkg::VALUE_W-1:0] random_value();
    logic [itrd_pkg::VALUE_W-1:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return raw;
      3:       return itrd_pkg::VALUE_W'($urandom_range(1, 40));
      4:       return 32'h7FFF_FFFF - $urandom_range(3);
      default: return {1'b0, raw[itrd_pkg::MAG_W-1:0] >> $urandom_range(itrd_pkg::MAG_W - 1)};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // Offer one value, idling first at random, and record its digits on transfer
  task automatic send_value(input logic [itrd_pkg::VALUE_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    value <= v;
    push  <= 1'b1;
    do @(posedge clk); while (full);
    predict_digits(v);
    values_sent++;
  endtask

  // Drain the block, then write the base register
  task automatic write_base(input logic [itrd_pkg::RADIX_W-1:0] r);
    push <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= r;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    base_setting  = r;
    base_writes++;
  endtask

  // Check each result transfer against the oldest digit owed; pop at random
  always @(posedge clk) begin : check_results
    itrd_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (digits_due.size() == 0) begin
          report_mismatch("result with nothing due, digit_char", digit_char, -1);
        end else begin
          want = digits_due.pop_front();
          if (digit_char !== want.digit_char) begin
            report_mismatch("digit_char", digit_char, want.digit_char);
          end
          if (is_last !== want.is_last) begin
            report_mismatch("is_last", is_last, want.is_last);
          end
          if (is_empty !== want.is_empty) begin
            report_mismatch("is_empty", is_empty, want.is_empty);
          end
          if (want.is_empty) begin
            empties_seen++;
          end else begin
            digits_seen++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // End the run if no transfer of any kind happens for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Base ten after reset: zero, both signs, one-digit edges, largest value
  task automatic test_reset_base();
    send_value(32'h0000_0000);
    send_value(32'h0000_0001);
    send_value(32'h0000_0009);
    send_value(32'h0000_000A);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
  endtask

  // Smallest and largest legal base, then hex with letter digits
  task automatic test_base_extremes();
    write_base(itrd_pkg::RADIX_W'(2));
    send_value(32'h7FFF_FFFF);
    send_value(32'h0000_0001);
    send_value(32'h0000_0002);
    write_base(itrd_pkg::RADIX_W'(36));
    send_value(32'h0000_0023);
    send_value(32'h0000_0024);
    send_value(32'h7FFF_FFFF);
    write_base(itrd_pkg::RADIX_W'(16));
    send_value(32'h7EAD_BEEF);
  endtask

  // Out-of-range bases saturate at two and thirty-six
  task automatic test_base_saturation();
    write_base(itrd_pkg::RADIX_W'(0));
    send_value(32'h0000_0005);
    write_base(itrd_pkg::RADIX_W'(1));
    send_value(32'h0000_0006);
    write_base(itrd_pkg::RADIX_W'(37));
    send_value(32'h0000_0023);
    write_base(itrd_pkg::RADIX_W'(63));
    send_value(32'h0000_050F);
    send_value(32'hFFFF_FFF9);
  endtask

  // Random values over several bases under one idling pattern
  task automatic test_random_values(input int sender_pct, input int receiver_pct);
    logic [itrd_pkg::RADIX_W-1:0] r;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int s = 0; s < SETTINGS_PER_RUN; s++) begin
      case (s)
        0:       r = itrd_pkg::RADIX_W'(2);
        1:       r = itrd_pkg::RADIX_W'(36);
        default: r = itrd_pkg::RADIX_W'($urandom_range(63));
      endcase
      write_base(r);
      repeat (ITEMS_PER_SETTING) send_value(random_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_base();
    test_base_extremes();
    test_base_saturation();
    test_random_values(22, 54);
    test_random_values(54, 22);
    test_random_values(0, 0);
    push <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Converted %0d values over %0d base writes, bases 0 to 63 incl. saturation",
             values_sent, base_writes);
    $display("Checked %0d digits and %0d empty markers under three idling patterns",
             digits_seen, empties_seen);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
